// ----- rtl/dhm_pkg.sv -----
// Shared types and constants for the degree histogram merge block.
// Holds the controller state type and the command and status structs.
// No dependencies.
`default_nettype none

package dhm_pkg;

    localparam int IN_DEGREE_W = 20;
    localparam int COUNT_W     = 24;
    localparam int RIDX_W      = 8;
    localparam int OUT_IDX_W   = 8;
    localparam int TOTAL_W     = 32;
    localparam int FRAC_BITS   = 8;
    localparam int AVG_W       = 40;
    localparam int RUNS_W      = 16;
    localparam logic [RUNS_W-1:0] RUNS_RESET = 16'd1;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_APPEND,
        ST_DROP,
        ST_RD_ISSUE,
        ST_RD_TAKE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic append;
        logic drop;
        logic rd_issue;
        logic rd_take;
        logic div_start;
        logic out_load;
    } dhm_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic full;
        logic div_busy;
        logic out_free;
    } dhm_status_t;

endpackage

`default_nettype wire

// ----- rtl/dhm_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Divides the fixed point dividend by the run count; uses dhm_pkg widths.
`default_nettype none

module dhm_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [dhm_pkg::AVG_W-1:0]     dividend,
    input  wire logic [dhm_pkg::RUNS_W-1:0]    divisor,
    output logic                               busy,
    output logic [dhm_pkg::AVG_W-1:0]          quotient
);

    localparam int CNT_W = $clog2(dhm_pkg::AVG_W + 1);

    logic                          busy_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [dhm_pkg::AVG_W-1:0]     quo_reg;
    logic [dhm_pkg::RUNS_W-1:0]    rem_reg;
    logic [dhm_pkg::RUNS_W-1:0]    div_reg;
    logic [dhm_pkg::RUNS_W:0]      trial;
    logic                          take;

    always_comb begin
        trial = {rem_reg, quo_reg[dhm_pkg::AVG_W-1]};
        take  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(dhm_pkg::AVG_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[dhm_pkg::AVG_W-2:0], take};
            if (take) begin
                rem_reg <= dhm_pkg::RUNS_W'(trial - {1'b0, div_reg});
            end else begin
                rem_reg <= trial[dhm_pkg::RUNS_W-1:0];
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/dhm_datapath.sv -----
// Datapath: request registers, key and total memories, scan logic,
// result and output registers, run count register. Uses dhm_pkg, dhm_divider.
`default_nettype none

module dhm_datapath #(
    parameter int TABLE_DEPTH = 256,
    parameter int DEGREE_BITS = 20
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire dhm_pkg::dhm_cmd_t                cmd,
    output dhm_pkg::dhm_status_t                  status,
    input  wire logic [dhm_pkg::IN_DEGREE_W-1:0]  s_degree,
    input  wire logic [dhm_pkg::COUNT_W-1:0]      s_node_count,
    input  wire logic [dhm_pkg::RIDX_W-1:0]       s_read_index,
    input  wire logic                             cfg_valid,
    input  wire logic [dhm_pkg::RUNS_W-1:0]       cfg_data,
    input  wire logic                             m_ready,
    output logic                                  m_valid,
    output logic [dhm_pkg::OUT_IDX_W-1:0]         m_entry_index,
    output logic [dhm_pkg::IN_DEGREE_W-1:0]       m_entry_degree,
    output logic [dhm_pkg::TOTAL_W-1:0]           m_total_count,
    output logic [dhm_pkg::AVG_W-1:0]             m_average_count,
    output logic                                  m_key_found,
    output logic                                  m_table_full,
    output logic                                  m_entry_valid
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W  = DEGREE_BITS;

    logic [KEY_W-1:0]                 key_mem [TABLE_DEPTH];
    logic [dhm_pkg::TOTAL_W-1:0]      tot_mem [TABLE_DEPTH];

    logic [KEY_W-1:0]                 key_reg;
    logic [dhm_pkg::COUNT_W-1:0]      cnt_reg;
    logic [dhm_pkg::RIDX_W-1:0]       ridx_reg;
    logic [FILL_W-1:0]                fill_reg;
    logic [FILL_W-1:0]                scan_reg;
    logic                             rd_pend_reg;
    logic [IDX_W-1:0]                 rd_idx_reg;
    logic [IDX_W-1:0]                 hit_idx_reg;
    logic [dhm_pkg::TOTAL_W-1:0]      hit_total_reg;
    logic                             rd_ok_reg;
    logic [KEY_W-1:0]                 key_rd_reg;
    logic [dhm_pkg::TOTAL_W-1:0]      tot_rd_reg;
    logic [dhm_pkg::RUNS_W-1:0]       runs_reg;

    logic [dhm_pkg::OUT_IDX_W-1:0]    res_idx_reg;
    logic [dhm_pkg::IN_DEGREE_W-1:0]  res_deg_reg;
    logic [dhm_pkg::TOTAL_W-1:0]      res_total_reg;
    logic                             res_found_reg;
    logic                             res_full_reg;
    logic                             res_valid_reg;

    logic                             m_valid_reg;
    logic [dhm_pkg::OUT_IDX_W-1:0]    m_idx_reg;
    logic [dhm_pkg::IN_DEGREE_W-1:0]  m_deg_reg;
    logic [dhm_pkg::TOTAL_W-1:0]      m_total_reg;
    logic [dhm_pkg::AVG_W-1:0]        m_avg_reg;
    logic                             m_found_reg;
    logic                             m_full_reg;
    logic                             m_evalid_reg;

    logic [31:0]                      deg_ext;
    logic [31:0]                      ridx_ext;
    logic [31:0]                      hit_idx_ext;
    logic [31:0]                      fill_ext;
    logic [31:0]                      key_ext;
    logic [31:0]                      key_rd_ext;
    logic [KEY_W-1:0]                 s_key;
    logic                             scan_live;
    logic                             rd_ok;
    logic                             rd_en;
    logic [IDX_W-1:0]                 rd_addr;
    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [dhm_pkg::TOTAL_W-1:0]      wr_total;
    logic [dhm_pkg::TOTAL_W:0]        sum;
    logic [dhm_pkg::TOTAL_W-1:0]      sat_sum;
    logic [dhm_pkg::RUNS_W-1:0]       divisor;
    logic                             div_busy;
    logic [dhm_pkg::AVG_W-1:0]        quotient;

    always_comb begin
        deg_ext     = 32'(s_degree);
        s_key       = deg_ext[KEY_W-1:0];
        ridx_ext    = 32'(ridx_reg);
        hit_idx_ext = 32'(hit_idx_reg);
        fill_ext    = 32'(fill_reg);
        key_ext     = 32'(key_reg);
        key_rd_ext  = 32'(key_rd_reg);
        scan_live   = scan_reg < fill_reg;
        rd_ok       = ridx_ext < fill_ext;
        rd_en       = (cmd.scan && scan_live) || cmd.rd_issue;
        rd_addr     = cmd.rd_issue ? ridx_ext[IDX_W-1:0] : scan_reg[IDX_W-1:0];
        sum         = {1'b0, hit_total_reg} + (dhm_pkg::TOTAL_W + 1)'(cnt_reg);
        sat_sum     = sum[dhm_pkg::TOTAL_W] ? '1 : sum[dhm_pkg::TOTAL_W-1:0];
        wr_en       = cmd.update || cmd.append;
        wr_addr     = cmd.update ? hit_idx_reg : fill_reg[IDX_W-1:0];
        wr_total    = cmd.update ? sat_sum : dhm_pkg::TOTAL_W'(cnt_reg);
        divisor     = (runs_reg == '0) ? dhm_pkg::RUNS_W'(1) : runs_reg;
    end

    always_comb begin
        status.hit       = rd_pend_reg && (key_rd_reg == key_reg);
        status.scan_done = !rd_pend_reg && !scan_live;
        status.full      = fill_reg == FILL_W'(TABLE_DEPTH);
        status.div_busy  = div_busy;
        status.out_free  = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= key_reg;
            tot_mem[wr_addr] <= wr_total;
        end
        if (rd_en) begin
            key_rd_reg <= key_mem[rd_addr];
            tot_rd_reg <= tot_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            scan_reg    <= '0;
            rd_pend_reg <= 1'b0;
            runs_reg    <= dhm_pkg::RUNS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                runs_reg <= cfg_data;
            end
            if (cmd.load) begin
                scan_reg    <= '0;
                rd_pend_reg <= 1'b0;
            end else if (cmd.scan) begin
                rd_pend_reg <= scan_live;
                if (scan_live) begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            if (cmd.append) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg      <= s_key;
            cnt_reg      <= s_node_count;
            ridx_reg     <= s_read_index;
        end
        if (cmd.scan && scan_live) begin
            rd_idx_reg <= scan_reg[IDX_W-1:0];
        end
        if (cmd.scan) begin
            hit_idx_reg   <= rd_idx_reg;
            hit_total_reg <= tot_rd_reg;
        end
        if (cmd.rd_issue) begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.update) begin
            res_idx_reg   <= hit_idx_ext[dhm_pkg::OUT_IDX_W-1:0];
            res_deg_reg   <= key_ext[dhm_pkg::IN_DEGREE_W-1:0];
            res_total_reg <= sat_sum;
            res_found_reg <= 1'b1;
            res_full_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else if (cmd.append) begin
            res_idx_reg   <= fill_ext[dhm_pkg::OUT_IDX_W-1:0];
            res_deg_reg   <= key_ext[dhm_pkg::IN_DEGREE_W-1:0];
            res_total_reg <= dhm_pkg::TOTAL_W'(cnt_reg);
            res_found_reg <= 1'b0;
            res_full_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else if (cmd.drop) begin
            res_idx_reg   <= '0;
            res_deg_reg   <= key_ext[dhm_pkg::IN_DEGREE_W-1:0];
            res_total_reg <= '0;
            res_found_reg <= 1'b0;
            res_full_reg  <= 1'b1;
            res_valid_reg <= 1'b0;
        end else if (cmd.rd_take) begin
            res_idx_reg   <= ridx_reg;
            res_found_reg <= 1'b0;
            res_full_reg  <= 1'b0;
            res_valid_reg <= rd_ok_reg;
            if (rd_ok_reg) begin
                res_deg_reg   <= key_rd_ext[dhm_pkg::IN_DEGREE_W-1:0];
                res_total_reg <= tot_rd_reg;
            end else begin
                res_deg_reg   <= '0;
                res_total_reg <= '0;
            end
        end
        if (cmd.out_load) begin
            m_idx_reg    <= res_idx_reg;
            m_deg_reg    <= res_deg_reg;
            m_total_reg  <= res_total_reg;
            m_avg_reg    <= quotient;
            m_found_reg  <= res_found_reg;
            m_full_reg   <= res_full_reg;
            m_evalid_reg <= res_valid_reg;
        end
    end

    dhm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({res_total_reg, dhm_pkg::FRAC_BITS'(0)}),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign m_valid         = m_valid_reg;
    assign m_entry_index   = m_idx_reg;
    assign m_entry_degree  = m_deg_reg;
    assign m_total_count   = m_total_reg;
    assign m_average_count = m_avg_reg;
    assign m_key_found     = m_found_reg;
    assign m_table_full    = m_full_reg;
    assign m_entry_valid   = m_evalid_reg;

endmodule

`default_nettype wire

// ----- rtl/dhm_ctrl.sv -----
// Controller state machine: sequences scan, update, read, divide and output.
// Uses dhm_pkg command and status structs.
`default_nettype none

module dhm_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_req_type,
    output logic                       s_ready,
    input  wire dhm_pkg::dhm_status_t  status,
    output dhm_pkg::dhm_cmd_t          cmd
);

    dhm_pkg::ctrl_state_t state_reg;
    dhm_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dhm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dhm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_req_type == dhm_pkg::REQ_READ) ?
                                 dhm_pkg::ST_RD_ISSUE : dhm_pkg::ST_SCAN;
                end
            end
            dhm_pkg::ST_SCAN: begin
                if (status.hit) begin
                    state_next = dhm_pkg::ST_UPDATE;
                end else if (status.scan_done) begin
                    state_next = status.full ? dhm_pkg::ST_DROP : dhm_pkg::ST_APPEND;
                end
            end
            dhm_pkg::ST_UPDATE, dhm_pkg::ST_APPEND, dhm_pkg::ST_DROP,
            dhm_pkg::ST_RD_TAKE: begin
                state_next = dhm_pkg::ST_DIV_START;
            end
            dhm_pkg::ST_RD_ISSUE: begin
                state_next = dhm_pkg::ST_RD_TAKE;
            end
            dhm_pkg::ST_DIV_START: begin
                state_next = dhm_pkg::ST_DIV_WAIT;
            end
            dhm_pkg::ST_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = dhm_pkg::ST_OUT;
                end
            end
            dhm_pkg::ST_OUT: begin
                if (status.out_free) begin
                    state_next = dhm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dhm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        case (state_reg)
            dhm_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            dhm_pkg::ST_SCAN:      cmd.scan      = 1'b1;
            dhm_pkg::ST_UPDATE:    cmd.update    = 1'b1;
            dhm_pkg::ST_APPEND:    cmd.append    = 1'b1;
            dhm_pkg::ST_DROP:      cmd.drop      = 1'b1;
            dhm_pkg::ST_RD_ISSUE:  cmd.rd_issue  = 1'b1;
            dhm_pkg::ST_RD_TAKE:   cmd.rd_take   = 1'b1;
            dhm_pkg::ST_DIV_START: cmd.div_start = 1'b1;
            dhm_pkg::ST_DIV_WAIT:  cmd       = '0;
            dhm_pkg::ST_OUT:       cmd.out_load  = status.out_free;
            default:               cmd       = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/degree_histogram_merge_core.sv -----
// Top level of the degree histogram merge block.
// Joins dhm_ctrl and dhm_datapath; uses dhm_pkg.
//
// Usage:
//   s_ channel: one request per handshake. Add (s_req_type 0) merges a
//   (degree, node count) pair into the table; read (s_req_type 1) returns
//   entry s_read_index. m_ channel: exactly one result per request.
//   cfg channel: writes runs_to_average, always ready; write it only
//   while no request is in flight.
// Sequencing:
//   One request at a time. An add scans the table linearly, reading one
//   entry per cycle through the single registered memory read port, with
//   the fill and drain of that port; it then writes the entry unless it is
//   dropped, starts the divider for its 40 quotient bits and loads the
//   output register. A read also passes through the divider. The next
//   request is taken in the cycle after the result is loaded, even if the
//   result has not been taken.
// Reset: table empties at once (fill count cleared), runs_to_average is 1,
//   no result pending. Memory contents are not cleared.
// Stall: a held result blocks only the next result; the block waits
//   with that result computed until m_ready rises.
`default_nettype none

module degree_histogram_merge_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int DEGREE_BITS = 20
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_req_type,
    input  wire logic [dhm_pkg::IN_DEGREE_W-1:0]  s_degree,
    input  wire logic [dhm_pkg::COUNT_W-1:0]      s_node_count,
    input  wire logic [dhm_pkg::RIDX_W-1:0]       s_read_index,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dhm_pkg::RUNS_W-1:0]       cfg_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [dhm_pkg::OUT_IDX_W-1:0]         m_entry_index,
    output logic [dhm_pkg::IN_DEGREE_W-1:0]       m_entry_degree,
    output logic [dhm_pkg::TOTAL_W-1:0]           m_total_count,
    output logic [dhm_pkg::AVG_W-1:0]             m_average_count,
    output logic                                  m_key_found,
    output logic                                  m_table_full,
    output logic                                  m_entry_valid
);

    dhm_pkg::dhm_cmd_t    cmd;
    dhm_pkg::dhm_status_t status;

    assign cfg_ready = 1'b1;

    dhm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    dhm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DEGREE_BITS (DEGREE_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_degree        (s_degree),
        .s_node_count    (s_node_count),
        .s_read_index    (s_read_index),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_entry_index   (m_entry_index),
        .m_entry_degree  (m_entry_degree),
        .m_total_count   (m_total_count),
        .m_average_count (m_average_count),
        .m_key_found     (m_key_found),
        .m_table_full    (m_table_full),
        .m_entry_valid   (m_entry_valid)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !status.div_busy)
        else $error("divider busy while controller idle");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_key_found && m_table_full) &&
                    !(m_entry_valid && (m_key_found || m_table_full)))
        else $error("conflicting result flags");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |-> (m_total_count == '0) && (m_average_count == '0))
        else $error("dropped add carries a nonzero total");

endmodule

`default_nettype wire
